FILE: hw/rtl/i2cs_pkg.sv
// shared types, constants and codes for the i2c transaction sequencer
package i2cs_pkg;

    // byte store depth
    localparam int BUFFER_DEPTH = 32;
    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    // request kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    // bus controller status codes
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RSTART      = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    // acknowledge control codes
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    // transaction progress codes
    localparam logic [1:0] PROG_DONE  = 2'd0;
    localparam logic [1:0] PROG_BUSY  = 2'd1;
    localparam logic [1:0] PROG_ERROR = 2'd2;

    // input request payload
    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] slave_address;
        logic [5:0] write_length;
        logic [5:0] read_length;
        logic [4:0] buffer_index;
        logic [7:0] byte_value;
        logic [7:0] status_code;
    } t_in_item;

    // result payload
    typedef struct packed {
        logic       set_start;
        logic       clear_start;
        logic       set_stop;
        logic [1:0] ack_control;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] txn_status;
        logic [7:0] read_byte;
    } t_out_item;

    // sequencer state
    typedef struct packed {
        logic [1:0] progress;
        logic [6:0] target_address;
        logic [5:0] writes_left;
        logic [5:0] reads_left;
        logic [5:0] position;
    } t_state;

    // byte store access from the decision logic
    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic [5:0] rd_addr;
    } t_store_req;

    // true when a store address falls inside the store
    function automatic logic addr_in_range(input logic [5:0] addr);
        logic [8:0] wide;
        wide = 9'(addr);
        return wide < 9'(BUFFER_DEPTH);
    endfunction

endpackage

FILE: hw/rtl/i2cs_step.sv
// per-request decision logic: next state, store access and result
module i2cs_step (
    input  i2cs_pkg::t_in_item   i_item,
    input  i2cs_pkg::t_state     i_state,
    input  logic [7:0]           i_rd_data,
    output i2cs_pkg::t_state     o_state,
    output i2cs_pkg::t_store_req o_store,
    output i2cs_pkg::t_out_item  o_result
);
    import i2cs_pkg::*;

    logic [5:0] pos_base;
    logic [5:0] rd_addr;
    logic [7:0] rd_byte;
    logic [5:0] reads_dec;

    // position used by the write data phase, reset on address ack
    assign pos_base  = (i_item.status_code == ST_ADDR_W_ACK) ? 6'd0 : i_state.position;
    assign reads_dec = i_state.reads_left - 6'd1;

    // store read address, out of range reads give zero
    always_comb begin
        rd_addr = (i_item.kind == KIND_READ) ? 6'(i_item.buffer_index) : pos_base;
        rd_byte = addr_in_range(rd_addr) ? i_rd_data : 8'd0;
    end

    // request decode
    always_comb begin
        o_state         = i_state;
        o_store.wr_en   = 1'b0;
        o_store.wr_addr = i_state.position;
        o_store.wr_data = i_item.byte_value;
        o_store.rd_addr = rd_addr;
        o_result        = '0;

        unique case (i_item.kind)
            KIND_LOAD: begin
                o_store.wr_en   = 1'b1;
                o_store.wr_addr = 6'(i_item.buffer_index);
            end
            KIND_START: begin
                o_state.target_address = i_item.slave_address;
                o_state.writes_left    = i_item.write_length;
                o_state.reads_left     = i_item.read_length;
                o_state.progress       = PROG_BUSY;
                o_result.set_start     = 1'b1;
            end
            KIND_STATUS: begin
                unique case (i_item.status_code) inside
                    ST_START, ST_RSTART: begin
                        o_result.clear_start = 1'b1;
                        o_result.tx_valid    = 1'b1;
                        o_result.tx_byte     = {i_state.target_address,
                                                (i_state.writes_left == 6'd0)};
                    end
                    ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
                        o_state.position = pos_base;
                        if (i_state.writes_left != 6'd0) begin
                            o_result.tx_valid   = 1'b1;
                            o_result.tx_byte    = rd_byte;
                            o_state.position    = pos_base + 6'd1;
                            o_state.writes_left = i_state.writes_left - 6'd1;
                        end else if (i_state.reads_left != 6'd0) begin
                            o_result.set_start = 1'b1;
                        end else begin
                            o_result.set_stop = 1'b1;
                            o_state.progress  = PROG_DONE;
                        end
                    end
                    ST_ADDR_R_ACK: begin
                        o_state.position     = 6'd0;
                        o_result.ack_control = (i_state.reads_left == 6'd1) ? ACK_NACK : ACK_ACK;
                    end
                    ST_DATA_R_ACK: begin
                        if (i_state.reads_left != 6'd0) begin
                            o_store.wr_en        = 1'b1;
                            o_state.position     = i_state.position + 6'd1;
                            o_state.reads_left   = reads_dec;
                            o_result.ack_control = (reads_dec == 6'd1) ? ACK_NACK : ACK_ACK;
                        end
                    end
                    ST_DATA_R_NACK: begin
                        o_store.wr_en     = 1'b1;
                        o_state.position  = i_state.position + 6'd1;
                        if (i_state.reads_left != 6'd0) begin
                            o_state.reads_left = reads_dec;
                        end
                        o_result.set_stop = 1'b1;
                        o_state.progress  = PROG_DONE;
                    end
                    default: begin
                        o_result.set_stop = 1'b1;
                        o_state.progress  = PROG_ERROR;
                    end
                endcase
            end
            KIND_READ: begin
                o_result.read_byte = rd_byte;
            end
            default: begin
                o_state = i_state;
            end
        endcase

        // writes beyond the store are dropped
        if (!addr_in_range(o_store.wr_addr)) begin
            o_store.wr_en = 1'b0;
        end

        o_result.txn_status = o_state.progress;
    end

endmodule

FILE: hw/rtl/i2c_master_transaction_sequencer_top.sv
// Top level of the i2c write-then-read transaction sequencer.
// The result of an accepted request is captured in the output register on the following clock edge.
// Throughput: one request per cycle; the single output register sets the pace and
// a new request is taken whenever that register is empty or being drained.
// Reset clears the progress and transaction counters; the byte store is not cleared
// and holds undefined data until written.
module i2c_master_transaction_sequencer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  i2cs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2cs_pkg::t_out_item o_out_data
);
    import i2cs_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_store_req store_req;
    t_out_item  n_result;
    t_out_item  r_result;
    logic       r_valid;
    logic       in_fire;
    logic [7:0] rd_data;
    logic [8:0] rd_wide;
    logic [8:0] wr_wide;

    logic [7:0] r_store [BUFFER_DEPTH];

    // request handshake
    assign o_in_stall = r_valid && i_out_stall;
    assign in_fire    = i_in_valid && !o_in_stall;

    // byte store read
    assign rd_wide = 9'(store_req.rd_addr);
    assign wr_wide = 9'(store_req.wr_addr);
    assign rd_data = r_store[rd_wide[IDX_W-1:0]];

    // decision logic
    i2cs_step u_step (
        .i_item    (i_in_data),
        .i_state   (r_state),
        .i_rd_data (rd_data),
        .o_state   (n_state),
        .o_store   (store_req),
        .o_result  (n_result)
    );

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (!o_in_stall) begin
                r_valid <= i_in_valid;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    // byte store write
    always_ff @(posedge i_clk) begin
        if (in_fire && store_req.wr_en) begin
            r_store[wr_wide[IDX_W-1:0]] <= store_req.wr_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_result;

endmodule

FILE: bench/tb.sv
// self-checking testbench for the i2c write-then-read transaction sequencer
module tb;
    import i2cs_pkg::*;

    // cycles from an accepted request to its result, plus margin
    localparam int RESULT_LATENCY = 1;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 3;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    i2c_master_transaction_sequencer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock, period 20
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted sequencer state
    logic [1:0] sq_progress;
    logic [6:0] sq_target;
    logic [5:0] sq_writes_left;
    logic [5:0] sq_reads_left;
    logic [5:0] sq_pos;
    logic [7:0] sq_bytes [BUFFER_DEPTH];

    // results predicted but not yet seen
    t_out_item pending_results [$];
    t_out_item rx_want;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int txn_count     = 0;
    int errors        = 0;

    // byte store read, zero outside the store
    function automatic logic [7:0] bytes_peek(input logic [5:0] addr);
        if (int'(addr) < BUFFER_DEPTH) return sq_bytes[addr[IDX_W-1:0]];
        return 8'h00;
    endfunction

    // byte store write, dropped outside the store
    function automatic void bytes_poke(input logic [5:0] addr, input logic [7:0] val);
        if (int'(addr) < BUFFER_DEPTH) sq_bytes[addr[IDX_W-1:0]] = val;
    endfunction

    function automatic void pos_step();
        sq_pos = sq_pos + 6'd1;
    endfunction

    // next-state and result of one request
    function automatic t_out_item predict_result(input t_in_item rq);
        t_out_item res;
        res = '0;
        case (rq.kind)
            KIND_LOAD: begin
                bytes_poke({1'b0, rq.buffer_index}, rq.byte_value);
            end
            KIND_START: begin
                sq_target      = rq.slave_address;
                sq_writes_left = rq.write_length;
                sq_reads_left  = rq.read_length;
                sq_progress    = PROG_BUSY;
                res.set_start  = 1'b1;
            end
            KIND_STATUS: begin
                case (rq.status_code)
                    ST_START, ST_RSTART: begin
                        res.clear_start = 1'b1;
                        res.tx_valid    = 1'b1;
                        res.tx_byte     = {sq_target, (sq_writes_left != 0) ? 1'b0 : 1'b1};
                    end
                    ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
                        if (rq.status_code == ST_ADDR_W_ACK) sq_pos = '0;
                        if (sq_writes_left != 0) begin
                            res.tx_valid   = 1'b1;
                            res.tx_byte    = bytes_peek(sq_pos);
                            pos_step();
                            sq_writes_left = sq_writes_left - 6'd1;
                        end else if (sq_reads_left != 0) begin
                            res.set_start = 1'b1;
                        end else begin
                            res.set_stop = 1'b1;
                            sq_progress  = PROG_DONE;
                        end
                    end
                    ST_ADDR_R_ACK: begin
                        sq_pos = '0;
                        res.ack_control = (sq_reads_left == 6'd1) ? ACK_NACK : ACK_ACK;
                    end
                    ST_DATA_R_ACK: begin
                        if (sq_reads_left != 0) begin
                            bytes_poke(sq_pos, rq.byte_value);
                            pos_step();
                            sq_reads_left   = sq_reads_left - 6'd1;
                            res.ack_control = (sq_reads_left == 6'd1) ? ACK_NACK : ACK_ACK;
                        end
                    end
                    ST_DATA_R_NACK: begin
                        bytes_poke(sq_pos, rq.byte_value);
                        pos_step();
                        // reads_left saturates at zero
                        if (sq_reads_left != 0) sq_reads_left = sq_reads_left - 6'd1;
                        res.set_stop = 1'b1;
                        sq_progress  = PROG_DONE;
                    end
                    default: begin
                        res.set_stop = 1'b1;
                        sq_progress  = PROG_ERROR;
                    end
                endcase
            end
            KIND_READ: begin
                res.read_byte = bytes_peek({1'b0, rq.buffer_index});
            end
        endcase
        res.txn_status = sq_progress;
        return res;
    endfunction

    // request builders; unused fields carry random bits
    function automatic t_in_item base_item(input logic [1:0] k);
        logic [63:0] raw;
        t_in_item    rq;
        raw = {$urandom, $urandom};
        rq = raw[$bits(t_in_item)-1:0];
        rq.kind = k;
        return rq;
    endfunction

    function automatic t_in_item mk_start(input logic [6:0] a, input logic [5:0] w,
                                          input logic [5:0] r);
        t_in_item rq;
        rq = base_item(KIND_START);
        rq.slave_address = a;
        rq.write_length  = w;
        rq.read_length   = r;
        return rq;
    endfunction

    function automatic t_in_item mk_status(input logic [7:0] code, input logic [7:0] rx);
        t_in_item rq;
        rq = base_item(KIND_STATUS);
        rq.status_code = code;
        rq.byte_value  = rx;
        return rq;
    endfunction

    function automatic t_in_item mk_load(input logic [4:0] idx, input logic [7:0] val);
        t_in_item rq;
        rq = base_item(KIND_LOAD);
        rq.buffer_index = idx;
        rq.byte_value   = val;
        return rq;
    endfunction

    function automatic t_in_item mk_read(input logic [4:0] idx);
        t_in_item rq;
        rq = base_item(KIND_READ);
        rq.buffer_index = idx;
        return rq;
    endfunction

    function automatic logic [7:0] legal_code();
        case ($urandom_range(6))
            0: return ST_START;
            1: return ST_RSTART;
            2: return ST_ADDR_W_ACK;
            3: return ST_DATA_W_ACK;
            4: return ST_ADDR_R_ACK;
            5: return ST_DATA_R_ACK;
            default: return ST_DATA_R_NACK;
        endcase
    endfunction

    // mostly short lengths, now and then long or past the store
    function automatic logic [5:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 6'($urandom_range(3));
        if (r < 85) return 6'($urandom_range(8, 4));
        if (r < 97) return 6'($urandom_range(32, 9));
        return 6'($urandom_range(63, 33));
    endfunction

    // send one request and record its predicted result
    task automatic push_request(input t_in_item rq);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= rq;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_result(rq));
        items_sent++;
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            errors++;
        end
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: %0h", o_out_data);
                errors++;
            end else begin
                rx_want = pending_results.pop_front();
                check_field("set_start",   8'(rx_want.set_start),   8'(o_out_data.set_start));
                check_field("clear_start", 8'(rx_want.clear_start), 8'(o_out_data.clear_start));
                check_field("set_stop",    8'(rx_want.set_stop),    8'(o_out_data.set_stop));
                check_field("ack_control", 8'(rx_want.ack_control), 8'(o_out_data.ack_control));
                check_field("tx_valid",    8'(rx_want.tx_valid),    8'(o_out_data.tx_valid));
                check_field("tx_byte",     rx_want.tx_byte,         o_out_data.tx_byte);
                check_field("txn_status",  8'(rx_want.txn_status),  8'(o_out_data.txn_status));
                check_field("read_byte",   rx_want.read_byte,       o_out_data.read_byte);
                results_seen++;
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // every store entry written once so no unwritten byte is ever read
    task automatic test_store_fill();
        for (int i = 0; i < BUFFER_DEPTH; i++) push_request(mk_load(5'(i), 8'($urandom)));
        wait_results();
    endtask

    // extremes, every status code and the corner cases
    task automatic test_directed_cases();
        idle_pct  = 28;
        stall_pct = 28;
        push_request(mk_load(5'd31, 8'hFF));
        push_request(mk_load(5'd0, 8'h00));
        push_request(mk_read(5'd31));
        push_request(mk_read(5'd0));
        // status event while no transaction runs
        push_request(mk_status(ST_DATA_W_ACK, 8'h00));
        // both lengths zero: read-mode address, then ack
        push_request(mk_start(7'h7F, 6'd0, 6'd0));
        push_request(mk_status(ST_START, 8'hFF));
        push_request(mk_status(ST_ADDR_R_ACK, 8'h00));
        // last read with nothing left to read
        push_request(mk_status(ST_DATA_R_NACK, 8'h3C));
        // write one byte, then restart mid-transaction
        push_request(mk_start(7'h00, 6'd1, 6'd1));
        push_request(mk_status(ST_START, 8'h00));
        push_request(mk_status(ST_ADDR_W_ACK, 8'h00));
        push_request(mk_start(7'h55, 6'd2, 6'd2));
        push_request(mk_status(ST_DATA_W_ACK, 8'h00));
        push_request(mk_status(ST_DATA_W_ACK, 8'h00));
        push_request(mk_status(ST_DATA_W_ACK, 8'h00));
        push_request(mk_status(ST_RSTART, 8'h00));
        push_request(mk_status(ST_ADDR_R_ACK, 8'h00));
        push_request(mk_status(ST_DATA_R_ACK, 8'hA5));
        push_request(mk_status(ST_DATA_R_NACK, 8'h5A));
        push_request(mk_read(5'd0));
        push_request(mk_read(5'd1));
        // data ack with no reads left, then unknown codes
        push_request(mk_status(ST_DATA_R_ACK, 8'h77));
        push_request(mk_status(8'h00, 8'h00));
        push_request(mk_status(8'hFF, 8'hFF));
        txn_count += 3;
        wait_results();
    endtask

    // position runs past the store and wraps at 64
    task automatic test_position_wrap();
        idle_pct  = 0;
        stall_pct = 0;
        push_request(mk_start(7'h2A, 6'd40, 6'd2));
        push_request(mk_status(ST_START, 8'h00));
        push_request(mk_status(ST_ADDR_W_ACK, 8'h00));
        repeat (40) push_request(mk_status(ST_DATA_W_ACK, 8'h00));
        push_request(mk_status(ST_RSTART, 8'h00));
        // received bytes beyond the store are dropped
        push_request(mk_status(ST_DATA_R_ACK, 8'h99));
        push_request(mk_status(ST_DATA_R_NACK, 8'h66));
        push_request(mk_start(7'h2A, 6'd30, 6'd0));
        repeat (31) push_request(mk_status(ST_DATA_W_ACK, 8'h00));
        txn_count += 2;
        wait_results();
    endtask

    // receiver holds off while requests keep coming, then a full drain
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        @(negedge i_clk);
        hold_left = 150;
        repeat (40) push_request(mk_status(legal_code(), 8'($urandom)));
        wait_results();
        stall_pct = 76;
        repeat (30) push_request(mk_read(5'($urandom)));
        wait_results();
    endtask

    task automatic random_store_access();
        if ($urandom_range(1)) push_request(mk_load(5'($urandom), 8'($urandom)));
        else push_request(mk_read(5'($urandom)));
    endtask

    task automatic random_noise();
        t_in_item rq;
        repeat ($urandom_range(4, 1)) begin
            rq = base_item(2'($urandom));
            if ($urandom_range(1)) rq.status_code = legal_code();
            push_request(rq);
        end
    endtask

    // one write-then-read transaction with random content, now and then abandoned part way
    task automatic random_transaction();
        logic [5:0] wl;
        logic [5:0] rl;
        logic [7:0] codes [$];
        wl = pick_len();
        rl = pick_len();
        codes.push_back($urandom_range(3) == 0 ? ST_RSTART : ST_START);
        if (wl != 0) begin
            codes.push_back(ST_ADDR_W_ACK);
            repeat (wl) codes.push_back(ST_DATA_W_ACK);
            if (rl != 0) codes.push_back(ST_RSTART);
        end
        if (rl != 0) begin
            codes.push_back(ST_ADDR_R_ACK);
            repeat (rl - 1) codes.push_back(ST_DATA_R_ACK);
            codes.push_back(ST_DATA_R_NACK);
        end else if (wl == 0) begin
            codes.push_back($urandom_range(1) ? ST_ADDR_R_ACK : ST_DATA_W_ACK);
        end
        if ($urandom_range(4) == 0) random_store_access();
        push_request(mk_start(7'($urandom), wl, rl));
        txn_count++;
        foreach (codes[i]) begin
            // broken sequence: abandon part way
            if ($urandom_range(99) < 3) break;
            if ($urandom_range(99) < 4) random_store_access();
            push_request(mk_status(codes[i], 8'($urandom)));
        end
    endtask

    // random traffic over the idle and stall mixes
    task automatic test_random_traffic();
        int goal;
        int r;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            goal = items_sent + 440;
            while (items_sent < goal) begin
                r = $urandom_range(99);
                if (r < 80) random_transaction();
                else if (r < 90) random_noise();
                else random_store_access();
            end
        end
        wait_results();
    endtask

    // main sequence
    initial begin
        sq_progress    = PROG_DONE;
        sq_target      = '0;
        sq_writes_left = '0;
        sq_reads_left  = '0;
        sq_pos         = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_store_fill();
        test_directed_cases();
        test_position_wrap();
        test_backpressure();
        test_random_traffic();
        stall_pct = 0;
        wait_results();
        $display("covered %0d requests over %0d transactions, %0d results compared",
                 items_sent, txn_count, results_seen);
        $display("store loads, read-backs, restarts, bad codes, wrap and backpressure");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/i2cs_pkg.sv
hw/rtl/i2cs_step.sv
hw/rtl/i2c_master_transaction_sequencer_top.sv
bench/tb.sv
